FILE: src/button_hue_color_controller_top_macros.svh
// Assertion macros for the button hue color controller checker.
// Used by the checker file only; no other dependencies.
`ifndef BUTTON_HUE_COLOR_CONTROLLER_TOP_MACROS_SVH
`define BUTTON_HUE_COLOR_CONTROLLER_TOP_MACROS_SVH

// Generic clocked assertion with a synchronous reset that disables it.
`define BHC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same, on the block's own clock and reset.
`define BHC_ASSERT_TOP(label, prop, msg) \
   `BHC_ASSERT(label, clock, reset, prop, msg)

`endif

FILE: src/bhc_pkg.sv
// Shared types and constants for the button hue color controller.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package bhc_pkg;

   // Opcodes of an input transfer
   localparam logic [1:0] OP_PRESS   = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_HOLD    = 2'd2;

   // Register indexes of the configuration port
   localparam logic [1:0] CSR_TAP_LIMIT = 2'd0;
   localparam logic [1:0] CSR_SWEEP     = 2'd1;
   localparam logic [1:0] CSR_LOW_LEVEL = 2'd2;

   localparam logic [15:0] TAP_LIMIT_RESET = 16'd500;
   localparam logic [15:0] SWEEP_RESET     = 16'd12000;
   localparam logic [2:0]  LOW_LEVEL_RESET = 3'd1;
   localparam logic [31:0] LAST_HOLD_RESET = 32'd500;

   localparam int HUE_RANGE = 360;
   localparam int DIV_BITS  = 41;                 // width of 360 * elapsed
   localparam int CNT_W     = $clog2(DIV_BITS);

   localparam logic [2:0]  QUARTERS_FULL = 3'd4;
   localparam logic [23:0] WHITE_BGR     = 24'hFFFFFF;

   typedef enum logic [2:0] {
      MODE_OFF         = 3'd0,
      MODE_SOLID_WHITE = 3'd1,
      MODE_NORMAL_HIGH = 3'd2,
      MODE_SOLID_HIGH  = 3'd3,
      MODE_SOLID_LOW   = 3'd4
   } lamp_mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MUL,
      ST_DIV,
      ST_ADD,
      ST_COLOR,
      ST_EMIT
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic decode;
      logic mul;
      logic div_step;
      logic hue_add;
      logic color;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       tap_hit;
      logic       div_last;
      logic       rsp_free;
   } dp_status_type;

endpackage

FILE: src/bhc_ctrl.sv
// Sequencer of the button hue color controller.
// Depends on bhc_pkg for the state, command and status types.
`timescale 1ns / 1ps

module bhc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  bhc_pkg::dp_status_type status,
   output bhc_pkg::ctrl_cmd_type  cmd
);

   bhc_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bhc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         bhc_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = bhc_pkg::ST_DECODE;
            end
         end
         bhc_pkg::ST_DECODE: begin
            cmd.decode = 1'b1;
            case (status.op)
               bhc_pkg::OP_RELEASE:
                  state_in = status.tap_hit ? bhc_pkg::ST_COLOR : bhc_pkg::ST_EMIT;
               bhc_pkg::OP_HOLD:
                  state_in = status.tap_hit ? bhc_pkg::ST_EMIT : bhc_pkg::ST_MUL;
               default:
                  state_in = bhc_pkg::ST_EMIT;
            endcase
         end
         bhc_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = bhc_pkg::ST_DIV;
         end
         bhc_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = bhc_pkg::ST_ADD;
            end
         end
         bhc_pkg::ST_ADD: begin
            cmd.hue_add = 1'b1;
            state_in    = bhc_pkg::ST_COLOR;
         end
         bhc_pkg::ST_COLOR: begin
            cmd.color = 1'b1;
            state_in  = bhc_pkg::ST_EMIT;
         end
         bhc_pkg::ST_EMIT: begin
            // hold until the output register can take the result
            if (status.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = bhc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bhc_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

FILE: src/bhc_datapath.sv
// Datapath of the button hue color controller: configuration, lamp state,
// bit-serial hue step divider, hue-to-RGB conversion and output register.
// Depends on bhc_pkg.
`timescale 1ns / 1ps

module bhc_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [1:0]             csr_addr,
   input  logic [15:0]            csr_wdata,
   input  logic [31:0]            req_tdata,
   input  logic [1:0]             req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [31:0]            rsp_tdata,
   input  bhc_pkg::ctrl_cmd_type  cmd,
   output bhc_pkg::dp_status_type status
);

   localparam int DB = bhc_pkg::DIV_BITS;
   localparam int CW = bhc_pkg::CNT_W;

   logic [15:0] tap_ff, tap_in;
   logic [15:0] sweep_ff, sweep_in;
   logic [2:0]  lowq_ff, lowq_in;

   logic [1:0]  op_ff, op_in;
   logic [31:0] hold_ff, hold_in;
   bhc_pkg::lamp_mode_type mode_ff, mode_in;
   logic [8:0]  hue_ff, hue_in;
   logic [31:0] last_ff, last_in;
   logic        ind_ff, ind_in;
   logic        upd_ff, upd_in;

   logic [DB-1:0] prod_ff, prod_in;
   logic [15:0]   rem_ff, rem_in;
   logic [8:0]    qmod_ff, qmod_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   logic [23:0] color_ff, color_in;
   logic        solid_sent_ff, solid_sent_in;
   logic        solid_on_ff, solid_on_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;

   // divider and color terms
   logic [31:0] delta;
   logic [15:0] sweep_eff;
   logic [16:0] rem_sh;
   logic        qbit;
   logic [9:0]  qm2;
   logic [9:0]  hue_sum;
   logic [6:0]  hm;
   logic [5:0]  spread;
   logic [5:0]  frac;
   logic [2:0]  q;
   logic [10:0] full_w;
   logic [7:0]  qm;
   logic [11:0] part_w;
   logic [7:0]  full;
   logic [7:0]  part;
   logic [7:0]  red, green, blue;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff       <= bhc_pkg::TAP_LIMIT_RESET;
         sweep_ff     <= bhc_pkg::SWEEP_RESET;
         lowq_ff      <= bhc_pkg::LOW_LEVEL_RESET;
         mode_ff      <= bhc_pkg::MODE_OFF;
         hue_ff       <= '0;
         last_ff      <= bhc_pkg::LAST_HOLD_RESET;
         ind_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tap_ff       <= tap_in;
         sweep_ff     <= sweep_in;
         lowq_ff      <= lowq_in;
         mode_ff      <= mode_in;
         hue_ff       <= hue_in;
         last_ff      <= last_in;
         ind_ff       <= ind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      hold_ff       <= hold_in;
      upd_ff        <= upd_in;
      prod_ff       <= prod_in;
      rem_ff        <= rem_in;
      qmod_ff       <= qmod_in;
      cnt_ff        <= cnt_in;
      color_ff      <= color_in;
      solid_sent_ff <= solid_sent_in;
      solid_on_ff   <= solid_on_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // configuration writes
   always_comb begin
      tap_in   = tap_ff;
      sweep_in = sweep_ff;
      lowq_in  = lowq_ff;
      if (csr_we) begin
         case (csr_addr)
            bhc_pkg::CSR_TAP_LIMIT: tap_in   = csr_wdata;
            bhc_pkg::CSR_SWEEP:     sweep_in = csr_wdata;
            bhc_pkg::CSR_LOW_LEVEL: lowq_in  = csr_wdata[2:0];
            default:                ;
         endcase
      end
   end

   assign delta     = (hold_ff >= last_ff) ? (hold_ff - last_ff) : 32'd0;
   assign sweep_eff = (sweep_ff == 16'd0) ? 16'd1 : sweep_ff;
   assign rem_sh    = {rem_ff, prod_ff[DB-1]};
   assign qbit      = (rem_sh >= {1'b0, sweep_eff});
   assign qm2       = {qmod_ff, qbit};
   assign hue_sum   = {1'b0, hue_ff} + {1'b0, qmod_ff};

   // lamp state, divider and hue update
   always_comb begin
      op_in   = op_ff;
      hold_in = hold_ff;
      mode_in = mode_ff;
      hue_in  = hue_ff;
      last_in = last_ff;
      ind_in  = ind_ff;
      upd_in  = upd_ff;
      prod_in = prod_ff;
      rem_in  = rem_ff;
      qmod_in = qmod_ff;
      cnt_in  = cnt_ff;

      if (cmd.accept) begin
         op_in   = req_tuser;
         hold_in = req_tdata;
      end

      if (cmd.decode) begin
         upd_in = 1'b0;
         case (op_ff)
            bhc_pkg::OP_PRESS: begin
               ind_in = 1'b1;
            end
            bhc_pkg::OP_RELEASE: begin
               ind_in = 1'b0;
               if (status.tap_hit) begin
                  upd_in  = 1'b1;
                  mode_in = (mode_ff == bhc_pkg::MODE_SOLID_LOW) ? bhc_pkg::MODE_OFF
                          : bhc_pkg::lamp_mode_type'(mode_ff + 3'd1);
               end
            end
            bhc_pkg::OP_HOLD: begin
               if (status.tap_hit) begin
                  last_in = {16'd0, tap_ff};
               end else begin
                  upd_in = 1'b1;
               end
            end
            default: ;
         endcase
      end

      if (cmd.mul) begin
         prod_in = {{(DB-32){1'b0}}, delta} * DB'(bhc_pkg::HUE_RANGE);
         rem_in  = '0;
         qmod_in = '0;
         cnt_in  = CW'(DB - 1);
      end

      // one quotient bit per cycle; keep the quotient reduced mod 360
      if (cmd.div_step) begin
         rem_in  = qbit ? 16'(rem_sh - {1'b0, sweep_eff}) : rem_sh[15:0];
         prod_in = {prod_ff[DB-2:0], 1'b0};
         qmod_in = (qm2 >= 10'(bhc_pkg::HUE_RANGE)) ? 9'(qm2 - 10'(bhc_pkg::HUE_RANGE))
                 : qm2[8:0];
         cnt_in  = cnt_ff - CW'(1);
      end

      if (cmd.hue_add) begin
         hue_in  = (hue_sum >= 10'(bhc_pkg::HUE_RANGE))
                 ? 9'(hue_sum - 10'(bhc_pkg::HUE_RANGE)) : hue_sum[8:0];
         last_in = hold_ff;
      end
   end

   // full-saturation hue to RGB; 255/240 reduces to 17/16
   always_comb begin
      if (hue_ff >= 9'd240) begin
         hm = 7'(hue_ff - 9'd240);
      end else if (hue_ff >= 9'd120) begin
         hm = 7'(hue_ff - 9'd120);
      end else begin
         hm = hue_ff[6:0];
      end
      spread = (hm >= 7'd60) ? 6'(hm - 7'd60) : 6'(7'd60 - hm);
      frac   = 6'd60 - spread;
      if (mode_ff == bhc_pkg::MODE_SOLID_LOW) begin
         q = (lowq_ff > bhc_pkg::QUARTERS_FULL) ? bhc_pkg::QUARTERS_FULL : lowq_ff;
      end else begin
         q = bhc_pkg::QUARTERS_FULL;
      end
      full_w = {8'd0, q} * 11'd255;
      full   = full_w[9:2];
      qm     = {5'd0, q} * {2'd0, frac};
      part_w = {4'd0, qm} * 12'd17;
      part   = part_w[11:4];
      red   = '0;
      green = '0;
      blue  = '0;
      if (hue_ff < 9'd60) begin
         red = full;  green = part;
      end else if (hue_ff < 9'd120) begin
         red = part;  green = full;
      end else if (hue_ff < 9'd180) begin
         green = full; blue = part;
      end else if (hue_ff < 9'd240) begin
         green = part; blue = full;
      end else if (hue_ff < 9'd300) begin
         red = part;  blue = full;
      end else begin
         red = full;  blue = part;
      end
   end

   always_comb begin
      color_in      = color_ff;
      solid_sent_in = solid_sent_ff;
      solid_on_in   = solid_on_ff;
      if (cmd.color) begin
         case (mode_ff)
            bhc_pkg::MODE_SOLID_WHITE: begin
               solid_sent_in = 1'b1; solid_on_in = 1'b1; color_in = bhc_pkg::WHITE_BGR;
            end
            bhc_pkg::MODE_NORMAL_HIGH: begin
               solid_sent_in = 1'b1; solid_on_in = 1'b0; color_in = {blue, green, red};
            end
            bhc_pkg::MODE_SOLID_HIGH, bhc_pkg::MODE_SOLID_LOW: begin
               solid_sent_in = 1'b1; solid_on_in = 1'b1; color_in = {blue, green, red};
            end
            default: begin
               solid_sent_in = 1'b0; solid_on_in = 1'b0; color_in = '0;
            end
         endcase
      end
   end

   // output register: a transfer frees it, emit loads it
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         if (upd_ff) begin
            rsp_data_in = {4'd0, ind_ff, color_ff, solid_on_ff, solid_sent_ff, 1'b1};
         end else begin
            rsp_data_in = {4'd0, ind_ff, 27'd0};
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign status.op       = op_ff;
   assign status.tap_hit  = (hold_ff <= {16'd0, tap_ff});
   assign status.div_last = (cnt_ff == CW'(0));
   assign status.rsp_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: src/button_hue_color_controller_top.sv
// Button hue color controller: takes press, release and hold-report events
// and returns one lamp update result per event. A press, an unused opcode, a
// long release or a hold within the tap limit goes from decode straight to the
// emit step, which loads its result into the output register; a tap release
// passes through the color step first, and a hold report beyond the tap limit
// through the multiply step, the 41-step bit-serial divider that forms
// 360 * elapsed / sweep_time_ms one quotient bit per cycle, the hue add and
// the color step. A result still waiting in the output register holds the
// block in its last step. One event is in work at a time; the next is taken
// as soon as the previous result sits in the output register, even if it has
// not yet been taken.
// Depends on bhc_pkg, bhc_ctrl and bhc_datapath.
`timescale 1ns / 1ps

module button_hue_color_controller_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [15:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] hold_ms
   input  logic [1:0]  req_tuser,   // [1:0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [0] update_sent, [1] solid_sent, [2] solid_on,
                                    // [26:3] color_word, [27] indicator_on, [31:28] zero
);

   bhc_pkg::ctrl_cmd_type  cmd;
   bhc_pkg::dp_status_type status;

   bhc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bhc_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

FILE: src/bhc_checker.sv
// Port-level checker for the button hue color controller, bound to the top.
// Depends on button_hue_color_controller_top_macros.svh.
`timescale 1ns / 1ps
`include "button_hue_color_controller_top_macros.svh"

module bhc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   `BHC_ASSERT_TOP(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled result changed")
   `BHC_ASSERT_TOP(a_one_in_work, req_tvalid && req_tready |=> !req_tready, "second event taken while one is in work")
   `BHC_ASSERT_TOP(a_no_update_zero, rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[26:1] == 26'd0, "fields set without update")
   `BHC_ASSERT_TOP(a_solid_flag, rsp_tvalid && rsp_tdata[2] |-> rsp_tdata[1] && rsp_tdata[0], "solid mode without solid flag")

endmodule

bind button_hue_color_controller_top bhc_checker u_bhc_checker (.*);

FILE: tb/button_hue_color_controller_top_test.sv
`timescale 1ns / 1ps
// Self-checking bench for button_hue_color_controller_top: button events in, lamp updates out,
// every update compared against a cycle-free predictor of mode, hue and color.
// Depends on bhc_pkg and the controller RTL.

module button_hue_color_controller_top_test;

   localparam logic [1:0]  OP_UNUSED     = 2'd3;
   localparam int unsigned SETTLE_CYCLES = 60;
   localparam int unsigned CYCLE_LIMIT   = 1000000;
   localparam int unsigned EVENT_TARGET  = 1350;

   typedef struct packed {
      logic        update_sent;
      logic        solid_sent;
      logic        solid_on;
      logic [23:0] color_word;
      logic        indicator_on;
   } lamp_update_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_addr;
   logic [15:0] csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // [31:0] hold_ms
   logic [1:0]  req_tuser;   // [1:0] opcode
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // [0] update_sent, [1] solid_sent, [2] solid_on,
                             // [26:3] color_word, [27] indicator_on, [31:28] zero

   // predictor copy of registers and state
   logic [15:0]            tap_limit_ms       = bhc_pkg::TAP_LIMIT_RESET;
   logic [15:0]            sweep_time_ms      = bhc_pkg::SWEEP_RESET;
   logic [2:0]             low_level_quarters = bhc_pkg::LOW_LEVEL_RESET;
   bhc_pkg::lamp_mode_type lamp_mode          = bhc_pkg::MODE_OFF;
   int unsigned            hue_degrees        = 0;
   logic [31:0]            last_hold_time     = bhc_pkg::LAST_HOLD_RESET;
   logic                   indicator_level    = 1'b0;

   lamp_update_type pending_updates[$];
   int unsigned  events_sent   = 0;
   int unsigned  updates_seen  = 0;
   int unsigned  lamp_updates  = 0;
   int unsigned  csr_settings  = 0;
   int unsigned  error_count   = 0;
   int unsigned  cycle_count   = 0;
   bit           sender_idles   = 1'b1;
   bit           receiver_idles = 1'b1;

   button_hue_color_controller_top DUT (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d updates still pending", $time, pending_updates.size());
         $display("button_hue_color_controller_top regression: fail");
         $finish;
      end
   end

   function automatic logic [23:0] hue_to_bgr(int unsigned hue, int unsigned quarters);
      int unsigned h, hm, spread, full, part;
      logic [7:0]  r, g, b;
      h = hue % 360;
      hm = h % 120;
      spread = (hm >= 60) ? hm - 60 : 60 - hm;
      full = quarters * 255 / 4;
      part = quarters * 255 * (60 - spread) / 240;
      r = '0;
      g = '0;
      b = '0;
      if (h < 60) begin
         r = full[7:0]; g = part[7:0];
      end else if (h < 120) begin
         r = part[7:0]; g = full[7:0];
      end else if (h < 180) begin
         g = full[7:0]; b = part[7:0];
      end else if (h < 240) begin
         g = part[7:0]; b = full[7:0];
      end else if (h < 300) begin
         r = part[7:0]; b = full[7:0];
      end else begin
         r = full[7:0]; b = part[7:0];
      end
      return {b, g, r};
   endfunction

   // Advance the predictor by one event and return the update it causes.
   function automatic lamp_update_type predict_lamp_update(logic [1:0] op, logic [31:0] hold);
      lamp_update_type upd;
      logic [63:0]  elapsed, step, sweep;
      int unsigned  quarters;
      bit           issue;
      upd = '0;
      issue = 1'b0;
      case (op)
         bhc_pkg::OP_PRESS: indicator_level = 1'b1;
         bhc_pkg::OP_RELEASE: begin
            indicator_level = 1'b0;
            if (hold <= {16'd0, tap_limit_ms}) begin
               lamp_mode = (lamp_mode == bhc_pkg::MODE_SOLID_LOW) ? bhc_pkg::MODE_OFF
                         : bhc_pkg::lamp_mode_type'(lamp_mode + 3'd1);
               issue = 1'b1;
            end
         end
         bhc_pkg::OP_HOLD: begin
            if (hold <= {16'd0, tap_limit_ms}) begin
               last_hold_time = {16'd0, tap_limit_ms};
            end else begin
               // clamp a hold time behind the last one to zero elapsed
               elapsed = (hold >= last_hold_time) ? {32'd0, hold} - {32'd0, last_hold_time}
                                                  : 64'd0;
               sweep = (sweep_time_ms == 16'd0) ? 64'd1 : {48'd0, sweep_time_ms};
               step = (64'd360 * elapsed) / sweep;
               hue_degrees = (hue_degrees + int'(step % 64'd360)) % 360;
               last_hold_time = hold;
               issue = 1'b1;
            end
         end
         default: ;
      endcase
      if (issue) begin
         quarters = (low_level_quarters > bhc_pkg::QUARTERS_FULL) ? bhc_pkg::QUARTERS_FULL
                                                                  : low_level_quarters;
         upd.update_sent = 1'b1;
         case (lamp_mode)
            bhc_pkg::MODE_SOLID_WHITE: begin
               upd.solid_sent = 1'b1; upd.solid_on = 1'b1; upd.color_word = bhc_pkg::WHITE_BGR;
            end
            bhc_pkg::MODE_NORMAL_HIGH: begin
               upd.solid_sent = 1'b1;
               upd.color_word = hue_to_bgr(hue_degrees, bhc_pkg::QUARTERS_FULL);
            end
            bhc_pkg::MODE_SOLID_HIGH: begin
               upd.solid_sent = 1'b1; upd.solid_on = 1'b1;
               upd.color_word = hue_to_bgr(hue_degrees, bhc_pkg::QUARTERS_FULL);
            end
            bhc_pkg::MODE_SOLID_LOW: begin
               upd.solid_sent = 1'b1; upd.solid_on = 1'b1;
               upd.color_word = hue_to_bgr(hue_degrees, quarters);
            end
            default: ;
         endcase
      end
      upd.indicator_on = indicator_level;
      return upd;
   endfunction

   function automatic void check_field(string name, logic [23:0] want, logic [23:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
         error_count++;
      end
   endfunction

   // Compare every result transfer with the oldest pending update.
   always @(posedge clock) begin
      lamp_update_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_updates.size() == 0) begin
            $display("%0t: unexpected result, expected none actual %h", $time, rsp_tdata);
            error_count++;
         end else begin
            want = pending_updates.pop_front();
            updates_seen++;
            if (want.update_sent) lamp_updates++;
            check_field("update_sent", 24'(want.update_sent), 24'(rsp_tdata[0]));
            check_field("solid_sent", 24'(want.solid_sent), 24'(rsp_tdata[1]));
            check_field("solid_on", 24'(want.solid_on), 24'(rsp_tdata[2]));
            check_field("color_word", want.color_word, rsp_tdata[26:3]);
            check_field("indicator_on", 24'(want.indicator_on), 24'(rsp_tdata[27]));
            check_field("padding", 24'd0, 24'(rsp_tdata[31:28]));
         end
      end
   end

   // Result side: random stall bursts while idling is on, otherwise always ready.
   initial begin
      rsp_tready <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (receiver_idles && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   end

   task automatic send_event(logic [1:0] op, logic [31:0] hold);
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= hold;
      do @(posedge clock); while (!req_tready);
      pending_updates.push_back(predict_lamp_update(op, hold));
      events_sent++;
   endtask

   // Hold off the sender until every pending update has come back, then let the block settle.
   task automatic wait_for_updates();
      req_tvalid <= 1'b0;
      while (pending_updates.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_registers(logic [15:0] tap, logic [15:0] sweep, logic [2:0] level);
      wait_for_updates();
      csr_we    <= 1'b1;
      csr_addr  <= bhc_pkg::CSR_TAP_LIMIT;
      csr_wdata <= tap;
      @(posedge clock);
      csr_addr  <= bhc_pkg::CSR_SWEEP;
      csr_wdata <= sweep;
      @(posedge clock);
      csr_addr  <= bhc_pkg::CSR_LOW_LEVEL;
      csr_wdata <= {13'd0, level};
      @(posedge clock);
      csr_we <= 1'b0;
      tap_limit_ms       = tap;
      sweep_time_ms      = sweep;
      low_level_quarters = level;
      csr_settings++;
   endtask

   // Taps on the tap limit boundary, long releases and the unused opcode at reset settings.
   task automatic test_tap_and_modes();
      send_event(bhc_pkg::OP_HOLD, 32'd0);
      send_event(bhc_pkg::OP_PRESS, 32'hFFFF_FFFF);
      send_event(bhc_pkg::OP_RELEASE, 32'd0);
      send_event(bhc_pkg::OP_PRESS, 32'd0);
      send_event(bhc_pkg::OP_RELEASE, 32'd500);
      send_event(bhc_pkg::OP_PRESS, 32'd0);
      send_event(bhc_pkg::OP_RELEASE, 32'd501);
      send_event(OP_UNUSED, 32'hFFFF_FFFF);
      send_event(bhc_pkg::OP_RELEASE, 32'hFFFF_FFFF);
   endtask

   // Hue steps below one degree, a full sweep, a clamped negative elapsed time, mode wrap.
   task automatic test_hold_sweep();
      send_event(bhc_pkg::OP_PRESS, 32'd0);
      send_event(bhc_pkg::OP_HOLD, 32'd501);
      send_event(bhc_pkg::OP_HOLD, 32'd12501);
      send_event(bhc_pkg::OP_HOLD, 32'd13501);
      send_event(bhc_pkg::OP_HOLD, 32'hFFFF_FFFF);
      send_event(bhc_pkg::OP_HOLD, 32'd1000);
      send_event(bhc_pkg::OP_RELEASE, 32'd0);
      send_event(bhc_pkg::OP_RELEASE, 32'd0);
      send_event(bhc_pkg::OP_RELEASE, 32'd0);
      send_event(bhc_pkg::OP_HOLD, 32'd40000);
   endtask

   // Zero tap limit, zero sweep time, saturating brightness, then the upper extremes.
   task automatic test_register_extremes();
      program_registers(16'd0, 16'd0, 3'd7);
      send_event(bhc_pkg::OP_RELEASE, 32'd0);
      send_event(bhc_pkg::OP_RELEASE, 32'd0);
      send_event(bhc_pkg::OP_RELEASE, 32'd0);
      send_event(bhc_pkg::OP_HOLD, 32'd7);
      program_registers(16'hFFFF, 16'hFFFF, 3'd0);
      send_event(bhc_pkg::OP_HOLD, 32'h0001_0000);
      send_event(bhc_pkg::OP_HOLD, 32'h0002_0000);
   endtask

   task automatic test_random_sessions();
      int unsigned session, holds, k;
      logic [31:0] t;
      logic [15:0] tap, sweep;
      session = 0;
      while (events_sent < EVENT_TARGET) begin
         if (session % 40 == 39) begin
            case ($urandom_range(0, 2))
               0: tap = 16'd0;
               1: tap = 16'hFFFF;
               default: tap = 16'($urandom_range(0, 2000));
            endcase
            case ($urandom_range(0, 4))
               0: sweep = 16'd0;
               1: sweep = 16'd1;
               2: sweep = 16'hFFFF;
               3: sweep = 16'd360;
               default: sweep = 16'($urandom_range(1, 20000));
            endcase
            program_registers(tap, sweep, 3'($urandom_range(0, 7)));
         end else if (session % 15 == 14) begin
            wait_for_updates();
         end
         // drop all idling in the closing stretch
         if (events_sent > EVENT_TARGET * 85 / 100) begin
            sender_idles   = 1'b0;
            receiver_idles = 1'b0;
         end else begin
            sender_idles   = ($urandom_range(0, 4) != 0);
            receiver_idles = ($urandom_range(0, 4) != 0);
         end
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 4)) send_event(2'($urandom_range(0, 3)), $urandom());
         end else begin
            // press, hold reports with mostly rising hold time, release
            send_event(bhc_pkg::OP_PRESS, $urandom());
            t = $urandom_range(0, tap_limit_ms);
            holds = $urandom_range(0, 8);
            for (k = 0; k < holds; k++) begin
               if ($urandom_range(0, 9) == 0)
                  t = t - $urandom_range(0, 2000);
               else
                  t = t + $urandom_range(0, 2 * sweep_time_ms + 50);
               send_event(bhc_pkg::OP_HOLD, t);
            end
            if ($urandom_range(0, 1) == 0)
               send_event(bhc_pkg::OP_RELEASE, $urandom_range(0, tap_limit_ms));
            else
               send_event(bhc_pkg::OP_RELEASE, t + $urandom_range(0, 100));
         end
         session++;
      end
   endtask

   initial begin
      reset      <= 1'b1;
      csr_we     <= 1'b0;
      csr_addr   <= bhc_pkg::CSR_TAP_LIMIT;
      csr_wdata  <= '0;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= bhc_pkg::OP_PRESS;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_tap_and_modes();
      test_hold_sweep();
      test_register_extremes();
      test_random_sessions();
      wait_for_updates();
      $display("Covered %0d button events (taps, hold sweeps, noise, unused opcode)",
               events_sent);
      $display("and %0d results, %0d lamp updates, over %0d register settings",
               updates_seen, lamp_updates, csr_settings);
      if (error_count == 0) begin
         $display("button_hue_color_controller_top regression: pass");
      end else begin
         $display("%0d mismatches", error_count);
         $display("button_hue_color_controller_top regression: fail");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+src
src/bhc_pkg.sv
src/bhc_ctrl.sv
src/bhc_datapath.sv
src/button_hue_color_controller_top.sv
src/bhc_checker.sv
tb/button_hue_color_controller_top_test.sv
